@@ rtl/core/sdd_pkg.sv @@
`default_nettype none

package sdd_pkg;

  // Segment header and trailer codes seen on the serial link.
  localparam logic [7:0] HDR_TIME      = 8'h81;
  localparam logic [7:0] HDR_DATA_BASE = 8'h82;
  localparam logic [7:0] TRAILER_MIN   = 8'hF0;
  localparam logic [7:0] END_LO_FIX    = 8'd253;
  localparam logic [7:0] END_HI_FIX    = 8'd254;
  localparam logic [7:0] END_BOTH_FIX  = 8'd255;

  localparam logic [6:0] QUALITY_LOCKED  = 7'd100;
  localparam logic [9:0] COUNTDOWN_RESET = 10'd360;

  // Sample format codes; the unused code decodes as the 16-bit format.
  localparam logic [1:0] FMT_24 = 2'd0;
  localparam logic [1:0] FMT_18 = 2'd1;
  localparam logic [1:0] FMT_16 = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_VALID_INIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTDOWN_LOAD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_QUALITY  = 3'd4;

  // Depth of the queue between the framer and the decoder.
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_TIME,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SAMPLE   = 3'd0,
    KIND_TIME     = 3'd1,
    KIND_UNKNOWN  = 3'd2,
    KIND_BAD_TIME = 3'd3,
    KIND_BAD_DATA = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0] sample_format;
    logic [4:0] channel_count;
    logic       time_valid_init;
    logic [8:0] countdown_load;
    logic [6:0] unlock_quality;
  } cfg_t;

  // One classified segment, handed from the framer to the decoder.
  typedef struct packed {
    kind_t           kind;
    logic [3:0]      channel;
    logic [1:0]      fmt;
    logic [7:0]      d0;
    logic [7:0]      d1;
    logic [7:0]      d2;
    logic [7:0]      dend;
    logic [5:0][7:0] tbytes;
    logic            lock_bit;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ rtl/core/sdd_if.sv @@
`default_nettype none

interface sdd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sdd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [3:0]         channel;
  logic signed [24:0] sample;
  logic [7:0]         year;
  logic [7:0]         month;
  logic [7:0]         day;
  logic [7:0]         hour;
  logic [7:0]         minute;
  logic [7:0]         second;
  logic               gps_locked;
  logic [6:0]         time_quality;

  modport source (output valid, output kind, output channel, output sample,
                  output year, output month, output day, output hour,
                  output minute, output second, output gps_locked,
                  output time_quality, input ready);
  modport sink (input valid, input kind, input channel, input sample,
                input year, input month, input day, input hour,
                input minute, input second, input gps_locked,
                input time_quality, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sdd_front.sv @@
`default_nettype none

module sdd_front #(
  parameter int CHANNELS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  sdd_in_if.sink            in_chan,
  input  sdd_pkg::cfg_t     cfg,
  input  sdd_pkg::q_status_t q_status,
  output logic              push,
  output sdd_pkg::job_t     job
);
  import sdd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] tb_r [8];
  logic [7:0] tb_nxt [8];
  logic [7:0] db_r [4];
  logic [7:0] db_nxt [4];
  logic [3:0] ch_r, ch_nxt;
  logic       tv_r, tv_nxt;

  logic       accept;
  logic [7:0] b;
  logic [7:0] ub;
  logic [4:0] limit;
  logic [2:0] seg_len;
  logic [7:0] end_byte;

  assign in_chan.ready = !q_status.full;
  assign accept = in_chan.valid && in_chan.ready;
  assign b = in_chan.rx_byte;
  assign ub = b - HDR_DATA_BASE;
  assign limit = (cfg.channel_count < 5'(CHANNELS)) ? cfg.channel_count : 5'(CHANNELS);
  assign seg_len = (cfg.sample_format == FMT_24) ? 3'd4 : 3'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      idx_r   <= 3'd0;
      ch_r    <= 4'd0;
      tv_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      ch_r    <= ch_nxt;
      tv_r    <= tv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tb_r <= tb_nxt;
    db_r <= db_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    ch_nxt    = ch_r;
    tv_nxt    = tv_r;
    tb_nxt    = tb_r;
    db_nxt    = db_r;
    push      = 1'b0;
    job       = '0;
    end_byte  = 8'd0;
    if (accept) begin
      unique case (phase_r)
        PH_TIME: begin
          tb_nxt[idx_r] = b;
          if (idx_r < 3'd7) begin
            idx_nxt = idx_r + 3'd1;
          end else begin
            phase_nxt = PH_WAIT;
            idx_nxt   = 3'd0;
            push      = 1'b1;
            if (b < TRAILER_MIN) begin
              job.kind = KIND_BAD_TIME;
            end else begin
              tv_nxt       = 1'b1;
              job.kind     = KIND_TIME;
              job.tbytes   = {tb_r[5], tb_r[4], tb_r[3], tb_r[2], tb_r[1], tb_r[0]};
              job.lock_bit = tb_r[6][5];
            end
          end
        end
        PH_DATA: begin
          db_nxt[idx_r[1:0]] = b;
          if (({1'b0, idx_r[1:0]} + 3'd1) < seg_len) begin
            idx_nxt = idx_r + 3'd1;
          end else begin
            // The segment ends here; its trailer sits at the last index of
            // the length that is in force now.
            phase_nxt   = PH_WAIT;
            idx_nxt     = 3'd0;
            push        = 1'b1;
            end_byte    = (cfg.sample_format == FMT_24) ? db_nxt[3] : db_nxt[2];
            job.channel = ch_r;
            if (end_byte < TRAILER_MIN) begin
              job.kind = KIND_BAD_DATA;
            end else begin
              job.kind = KIND_SAMPLE;
              job.fmt  = (cfg.sample_format == FMT_24 || cfg.sample_format == FMT_18) ?
                         cfg.sample_format : FMT_16;
              job.d0   = db_nxt[0];
              job.d1   = db_nxt[1];
              job.d2   = db_nxt[2];
              job.dend = end_byte;
            end
          end
        end
        PH_WAIT: begin
          if (b == HDR_TIME) begin
            phase_nxt = PH_TIME;
            idx_nxt   = 3'd0;
          end else if (tv_r || cfg.time_valid_init) begin
            if (b >= HDR_DATA_BASE && ub < {3'b000, limit}) begin
              ch_nxt    = ub[3:0];
              phase_nxt = PH_DATA;
              idx_nxt   = 3'd0;
            end else begin
              push        = 1'b1;
              job.kind    = KIND_UNKNOWN;
              job.channel = ub[3:0];
            end
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sdd_queue.sv @@
`default_nettype none

module sdd_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  sdd_pkg::job_t       push_job,
  input  wire                 pop,
  output sdd_pkg::job_t       head,
  output sdd_pkg::q_status_t  status
);
  import sdd_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  job_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sdd_back.sv @@
`default_nettype none

module sdd_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sdd_pkg::cfg_t       cfg,
  input  sdd_pkg::q_status_t  q_status,
  input  sdd_pkg::job_t       head,
  output logic                pop,
  sdd_out_if.source           out_chan
);
  import sdd_pkg::*;

  // GPS lock tracking.
  logic        lock_r, lock_nxt;
  logic [9:0]  cd_r, cd_nxt;
  logic [6:0]  q_r, q_nxt;

  // Output register.
  logic        valid_r, valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [3:0]  ch_r, ch_nxt;
  logic [24:0] sample_r, sample_nxt;
  logic [5:0][7:0] tb_r, tb_nxt;
  logic        locked_r, locked_nxt;
  logic [6:0]  qual_r, qual_nxt;

  logic [7:0]  lo, hi;
  logic [24:0] decoded;

  assign pop = !q_status.empty && (!valid_r || out_chan.ready);

  // Sample decode with the high-bit restore rules of each format.
  always_comb begin
    lo      = head.d0;
    hi      = head.d1;
    decoded = '0;
    unique case (head.fmt)
      FMT_24: begin
        lo      = head.d0 + {head.dend[0], 7'b0};
        hi      = head.d1 + {head.dend[1], 7'b0};
        decoded = {1'b0, head.d2, hi, lo} - (head.dend[2] ? 25'h0800000 : 25'h0);
      end
      FMT_18: begin
        lo      = head.d0 + {head.dend[0], 7'b0};
        hi      = head.d1 + {head.dend[1], 7'b0};
        decoded = {9'b0, hi, lo} + (head.dend[2] ? 25'h0010000 : 25'h0)
                  - (head.dend[3] ? 25'h0020000 : 25'h0);
      end
      default: begin
        if (head.dend == END_LO_FIX || head.dend == END_BOTH_FIX) begin
          lo = head.d0 + 8'h80;
        end
        if (head.dend == END_HI_FIX || head.dend == END_BOTH_FIX) begin
          hi = head.d1 + 8'h80;
        end
        decoded = {{9{hi[7]}}, hi, lo};
      end
    endcase
  end

  always_comb begin
    lock_nxt   = lock_r;
    cd_nxt     = cd_r;
    q_nxt      = q_r;
    valid_nxt  = valid_r;
    kind_nxt   = kind_r;
    ch_nxt     = ch_r;
    sample_nxt = sample_r;
    tb_nxt     = tb_r;
    locked_nxt = locked_r;
    qual_nxt   = qual_r;
    if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
    if (pop) begin
      valid_nxt  = 1'b1;
      kind_nxt   = head.kind;
      ch_nxt     = '0;
      sample_nxt = '0;
      tb_nxt     = '0;
      locked_nxt = 1'b0;
      qual_nxt   = '0;
      unique case (head.kind) inside
        KIND_SAMPLE: begin
          ch_nxt     = head.channel;
          sample_nxt = decoded;
        end
        KIND_UNKNOWN, KIND_BAD_DATA: begin
          ch_nxt = head.channel;
        end
        KIND_TIME: begin
          if (head.lock_bit && !lock_r) begin
            lock_nxt = 1'b1;
            q_nxt    = QUALITY_LOCKED;
            cd_nxt   = {1'b0, cfg.countdown_load};
          end
          if (cd_nxt == 10'd0) begin
            lock_nxt = 1'b0;
            q_nxt    = cfg.unlock_quality;
          end
          // The countdown stops once it has gone negative.
          if (!cd_nxt[9]) begin
            cd_nxt = cd_nxt - 10'd1;
          end
          tb_nxt     = head.tbytes;
          locked_nxt = lock_nxt;
          qual_nxt   = q_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r  <= 1'b0;
      cd_r    <= COUNTDOWN_RESET;
      q_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      lock_r  <= lock_nxt;
      cd_r    <= cd_nxt;
      q_r     <= q_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    ch_r     <= ch_nxt;
    sample_r <= sample_nxt;
    tb_r     <= tb_nxt;
    locked_r <= locked_nxt;
    qual_r   <= qual_nxt;
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.kind         = kind_r;
  assign out_chan.channel      = ch_r;
  assign out_chan.sample       = signed'(sample_r);
  assign out_chan.year         = tb_r[0];
  assign out_chan.month        = tb_r[1];
  assign out_chan.day          = tb_r[2];
  assign out_chan.hour         = tb_r[5];
  assign out_chan.minute       = tb_r[4];
  assign out_chan.second       = tb_r[3];
  assign out_chan.gps_locked   = locked_r;
  assign out_chan.time_quality = qual_r;

endmodule

`default_nettype wire

@@ rtl/core/digitizer_segment_deframer.sv @@
// Segment deframer for a byte-wide digitizer serial link.
// in_chan carries one received byte per item (valid/ready). out_chan carries
// one result item per completed segment or rejected header: a decoded sample,
// a time record with GPS lock state, an unknown header, or a bad segment.
// Bytes that only extend a segment, or headers dropped before time is valid,
// give no result.
// The block takes one byte per cycle while the queue has room. The framer
// pushes each classified segment into a two-entry queue, and the decoder
// pops it from there and fills the output register.
// When the receiver stalls, the output register holds its item, the queue
// fills behind it, and in_chan.ready drops once the queue is full; it rises
// again in the cycle after the receiver takes an item.
// Synchronous reset clears the framer to hunting for a header, empties the
// queue and output, drops lock and quality to zero and reloads the countdown
// to 360. Configuration goes through cfg_we/cfg_index/cfg_data; the user
// must write it while no item is in flight; the block does not enforce it.
`default_nettype none

module digitizer_segment_deframer #(
  parameter int CHANNELS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  sdd_in_if.sink                           in_chan,
  sdd_out_if.source                        out_chan,
  input  wire                              cfg_we,
  input  wire [sdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [sdd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sdd_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_status;
  job_t      push_job;
  job_t      head;
  logic      push;
  logic      pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_FORMAT:   cfg_nxt.sample_format   = cfg_data[1:0];
        CFG_CHANNEL_COUNT:   cfg_nxt.channel_count   = cfg_data[4:0];
        CFG_TIME_VALID_INIT: cfg_nxt.time_valid_init = cfg_data[0];
        CFG_COUNTDOWN_LOAD:  cfg_nxt.countdown_load  = cfg_data[8:0];
        CFG_UNLOCK_QUALITY:  cfg_nxt.unlock_quality  = cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_format   <= FMT_24;
      cfg_r.channel_count   <= 5'd3;
      cfg_r.time_valid_init <= 1'b0;
      cfg_r.countdown_load  <= 9'd360;
      cfg_r.unlock_quality  <= 7'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sdd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg      (cfg_r),
    .q_status (q_status),
    .push     (push),
    .job      (push_job)
  );

  sdd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  sdd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

@@ rtl/core/sdd_checker.sv @@
`default_nettype none

module sdd_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               out_valid,
  input wire               out_ready,
  input wire [2:0]         out_kind,
  input wire [3:0]         out_channel,
  input wire signed [24:0] out_sample,
  input wire [7:0]         out_year,
  input wire               out_gps_locked,
  input wire [6:0]         out_time_quality
);
  import sdd_pkg::*;

  // A stalled result item keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_channel) && $stable(out_sample) && $stable(out_time_quality))
    else $error("stalled result item changed");

  // Reset leaves no result item pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid right after reset");

  // Only samples carry a sample value.
  a_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_SAMPLE |-> out_sample == 25'sd0)
    else $error("non-sample item carries a sample value");

  // Time and lock fields are zero outside time items.
  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TIME |->
    out_year == 8'd0 && !out_gps_locked && out_time_quality == 7'd0)
    else $error("non-time item carries time fields");

  // While locked the reported quality is always full.
  a_lock_quality: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TIME && out_gps_locked |->
    out_time_quality == QUALITY_LOCKED)
    else $error("locked time item with reduced quality");

endmodule

bind digitizer_segment_deframer sdd_checker u_sdd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_kind         (out_chan.kind),
  .out_channel      (out_chan.channel),
  .out_sample       (out_chan.sample),
  .out_year         (out_chan.year),
  .out_gps_locked   (out_chan.gps_locked),
  .out_time_quality (out_chan.time_quality)
);

`default_nettype wire
